// ===== rtl/bse_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes, controller states, datapath operations and status bundle.
package bse_pkg;

    // Widths of the configuration registers and of the result fields.
    localparam int NW     = 6;
    localparam int MW     = 32;
    localparam int MIW    = 5;
    localparam int GCW    = 33;
    localparam int CFG_IW = 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_NUM_VARS   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE_BOUND = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ORDER_MODE = 2'd2;

    // Register values after reset.
    localparam logic [NW-1:0] NUM_VARS_RST   = 6'd8;
    localparam logic [NW-1:0] SIZE_BOUND_RST = 6'd32;
    localparam logic          ORDER_MODE_RST = 1'b0;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LEX_SEL,
        S_LEX_UPD,
        S_LEX_CMP,
        S_LEX_FIN,
        S_GF1_START,
        S_GF1_STEP,
        S_GRAY_HIT,
        S_GRAY_SIZE,
        S_GF2_START,
        S_GF2_STEP,
        S_GRAY_LAST,
        S_EXHAUST,
        S_EMIT
    } t_state;

    // Operations the controller asks of the datapath in one cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EXHAUST,
        OP_LEX_INIT,
        OP_LEX_CMP,
        OP_LEX_SEL,
        OP_LEX_REFILL,
        OP_LEX_RES,
        OP_GF_LOAD_CNT,
        OP_GF_START,
        OP_GF_STEP,
        OP_GRAY_HIT,
        OP_GRAY_SIZE,
        OP_SET_FIN,
        OP_EMIT
    } t_op;

    // Status the datapath reports back to the controller.
    typedef struct packed {
        logic mode;
        logic done;
        logic k_zero;
        logic m_zero;
        logic k_gt_m;
        logic k_ge_m;
        logic any_hit;
        logic start_found;
        logic start_fail;
        logic step_found;
        logic step_fail;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/bse_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences one enumeration step through the datapath.
module bse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bse_pkg::t_status i_status,
    output logic             o_stall,
    output bse_pkg::t_op     o_op
);

    bse_pkg::t_state r_state;
    bse_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bse_pkg::S_IDLE: begin
                if (i_valid) n_state = bse_pkg::S_DISPATCH;
            end
            bse_pkg::S_DISPATCH: begin
                if (i_status.done) begin
                    n_state = bse_pkg::S_EMIT;
                end else if (i_status.mode) begin
                    n_state = bse_pkg::S_GF1_START;
                end else if (i_status.k_zero) begin
                    n_state = i_status.m_zero ? bse_pkg::S_EMIT : bse_pkg::S_LEX_CMP;
                end else if (i_status.k_gt_m) begin
                    n_state = bse_pkg::S_EMIT;
                end else begin
                    n_state = bse_pkg::S_LEX_SEL;
                end
            end
            bse_pkg::S_LEX_SEL: begin
                if (i_status.any_hit) begin
                    n_state = bse_pkg::S_LEX_UPD;
                end else if (i_status.k_ge_m) begin
                    n_state = bse_pkg::S_EMIT;
                end else begin
                    n_state = bse_pkg::S_LEX_CMP;
                end
            end
            bse_pkg::S_LEX_UPD: n_state = bse_pkg::S_LEX_CMP;
            bse_pkg::S_LEX_CMP: n_state = bse_pkg::S_LEX_FIN;
            bse_pkg::S_LEX_FIN: n_state = bse_pkg::S_EMIT;
            bse_pkg::S_GF1_START: begin
                if (i_status.start_fail) begin
                    n_state = bse_pkg::S_EXHAUST;
                end else if (i_status.start_found) begin
                    n_state = bse_pkg::S_GRAY_HIT;
                end else begin
                    n_state = bse_pkg::S_GF1_STEP;
                end
            end
            bse_pkg::S_GF1_STEP: begin
                if (i_status.step_fail) begin
                    n_state = bse_pkg::S_EXHAUST;
                end else if (i_status.step_found) begin
                    n_state = bse_pkg::S_GRAY_HIT;
                end
            end
            bse_pkg::S_GRAY_HIT:  n_state = bse_pkg::S_GRAY_SIZE;
            bse_pkg::S_GRAY_SIZE: n_state = bse_pkg::S_GF2_START;
            bse_pkg::S_GF2_START: begin
                if (i_status.start_fail) begin
                    n_state = bse_pkg::S_GRAY_LAST;
                end else if (i_status.start_found) begin
                    n_state = bse_pkg::S_EMIT;
                end else begin
                    n_state = bse_pkg::S_GF2_STEP;
                end
            end
            bse_pkg::S_GF2_STEP: begin
                if (i_status.step_fail) begin
                    n_state = bse_pkg::S_GRAY_LAST;
                end else if (i_status.step_found) begin
                    n_state = bse_pkg::S_EMIT;
                end
            end
            bse_pkg::S_GRAY_LAST: n_state = bse_pkg::S_EMIT;
            bse_pkg::S_EXHAUST:   n_state = bse_pkg::S_EMIT;
            bse_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = bse_pkg::S_IDLE;
            end
            default: n_state = bse_pkg::S_IDLE;
        endcase
    end

    // Datapath operation and input stall for the current state.
    always_comb begin
        o_op    = bse_pkg::OP_NONE;
        o_stall = (r_state != bse_pkg::S_IDLE);
        unique case (r_state)
            bse_pkg::S_IDLE: begin
                if (i_valid) o_op = bse_pkg::OP_ACCEPT;
            end
            bse_pkg::S_DISPATCH: begin
                if (i_status.done) begin
                    o_op = bse_pkg::OP_EXHAUST;
                end else if (i_status.mode) begin
                    o_op = bse_pkg::OP_GF_LOAD_CNT;
                end else if (i_status.k_zero) begin
                    o_op = i_status.m_zero ? bse_pkg::OP_EXHAUST : bse_pkg::OP_LEX_INIT;
                end else if (i_status.k_gt_m) begin
                    o_op = bse_pkg::OP_EXHAUST;
                end else begin
                    o_op = bse_pkg::OP_LEX_CMP;
                end
            end
            bse_pkg::S_LEX_SEL: begin
                if (i_status.any_hit) begin
                    o_op = bse_pkg::OP_LEX_SEL;
                end else if (i_status.k_ge_m) begin
                    o_op = bse_pkg::OP_EXHAUST;
                end else begin
                    o_op = bse_pkg::OP_LEX_INIT;
                end
            end
            bse_pkg::S_LEX_UPD:   o_op = bse_pkg::OP_LEX_REFILL;
            bse_pkg::S_LEX_CMP:   o_op = bse_pkg::OP_LEX_CMP;
            bse_pkg::S_LEX_FIN:   o_op = bse_pkg::OP_LEX_RES;
            bse_pkg::S_GF1_START: o_op = bse_pkg::OP_GF_START;
            bse_pkg::S_GF1_STEP:  o_op = bse_pkg::OP_GF_STEP;
            bse_pkg::S_GRAY_HIT:  o_op = bse_pkg::OP_GRAY_HIT;
            bse_pkg::S_GRAY_SIZE: o_op = bse_pkg::OP_GRAY_SIZE;
            bse_pkg::S_GF2_START: o_op = bse_pkg::OP_GF_START;
            bse_pkg::S_GF2_STEP:  o_op = bse_pkg::OP_GF_STEP;
            bse_pkg::S_GRAY_LAST: o_op = bse_pkg::OP_SET_FIN;
            bse_pkg::S_EXHAUST:   o_op = bse_pkg::OP_EXHAUST;
            bse_pkg::S_EMIT: begin
                if (i_status.out_free) o_op = bse_pkg::OP_EMIT;
            end
            default: o_op = bse_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/bse_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration, combination indices, Gray counter search and result registers.
module bse_dpath #(
    parameter int VAR_LIMIT = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bse_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [bse_pkg::NW-1:0]     i_cfg_data,
    input  bse_pkg::t_op               i_op,
    input  logic                       i_restart,
    input  logic                       i_out_stall,
    output bse_pkg::t_status           o_status,
    output logic                       o_out_valid,
    output logic [bse_pkg::MW-1:0]     o_mask,
    output logic [bse_pkg::NW-1:0]     o_size,
    output logic                       o_subset_valid,
    output logic                       o_final
);

    localparam int NW  = bse_pkg::NW;
    localparam int MW  = bse_pkg::MW;
    localparam int MIW = bse_pkg::MIW;
    localparam int GCW = bse_pkg::GCW;
    localparam int IW  = (VAR_LIMIT > 1) ? $clog2(VAR_LIMIT) : 1;
    localparam int KW  = $clog2(VAR_LIMIT + 1);
    localparam int GW  = (VAR_LIMIT + 1 > GCW + 1) ? VAR_LIMIT + 1 : GCW + 1;
    localparam int PCW = $clog2(GW + 1);
    localparam int HW  = ((PCW > NW) ? PCW : NW) + 1;
    localparam int BW  = NW + 2;

    // Configuration registers.
    logic [NW-1:0] r_num_vars;
    logic [NW-1:0] r_size_bound;
    logic          r_order_mode;

    // Enumeration state.
    logic [IW-1:0]  r_idx [VAR_LIMIT];
    logic [KW-1:0]  r_k;
    logic [GCW-1:0] r_gcnt;
    logic           r_done;

    // Working registers of one step.
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_m;
    logic [VAR_LIMIT-1:0] r_hit;
    logic [IW-1:0]        r_sel;
    logic [IW-1:0]        r_selv;
    logic [GW-1:0]        r_c;
    logic [GW-1:0]        r_sh;
    logic [GW-1:0]        r_pbit;
    logic [GW-1:0]        r_low;
    logic [KW-1:0]        r_p;
    logic [GW-1:0]        r_x;

    // Result of the step and the output register.
    logic [MW-1:0] r_res_mask;
    logic [NW-1:0] r_res_size;
    logic          r_res_valid;
    logic          r_res_fin;
    logic          r_o_vld;
    logic [MW-1:0] r_o_mask;
    logic [NW-1:0] r_o_size;
    logic          r_o_valid_f;
    logic          r_o_fin;

    logic [NW-1:0]        eff_n;
    logic [NW-1:0]        eff_m;
    logic [VAR_LIMIT-1:0] c_hit;
    logic [IW-1:0]        c_sel;
    logic [IW-1:0]        c_selv;
    logic [KW-1:0]        c_k_inc;
    logic [MW-1:0]        c_lex_mask;
    logic [GW-1:0]        c_himask;
    logic [GW-1:0]        c_gy;
    logic [PCW-1:0]       c_pc_plain;
    logic [PCW-1:0]       c_pc_step;
    logic [HW-1:0]        c_m_h;
    logic                 c_start_fail;
    logic                 c_start_found;
    logic                 c_p_end;
    logic                 c_hw_le;
    logic                 c_hw1_le;
    logic [GW-1:0]        c_x_base;
    logic [GW-1:0]        c_step_x;
    logic                 c_step_acc;
    logic                 c_step_over;
    logic                 c_step_fail;
    logic                 c_step_found;
    logic [GW-1:0]        c_gray;
    logic [GW-1:0]        c_load;

    // Configuration write decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars   <= bse_pkg::NUM_VARS_RST;
            r_size_bound <= bse_pkg::SIZE_BOUND_RST;
            r_order_mode <= bse_pkg::ORDER_MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bse_pkg::CFG_NUM_VARS:   r_num_vars   <= i_cfg_data;
                bse_pkg::CFG_SIZE_BOUND: r_size_bound <= i_cfg_data;
                bse_pkg::CFG_ORDER_MODE: r_order_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective variable count and size bound.
    assign eff_n = (r_num_vars > NW'(VAR_LIMIT)) ? NW'(VAR_LIMIT) : r_num_vars;
    assign eff_m = (r_size_bound > eff_n) ? eff_n : r_size_bound;

    // An index can still grow while it stays below n - k + its position.
    always_comb begin
        for (int j = 0; j < VAR_LIMIT; j++) begin
            c_hit[j] = (KW'(j) < r_k)
                       && (BW'(r_idx[j]) < (BW'(r_n) + BW'(j) - BW'(r_k)));
        end
    end

    // Rightmost index that can grow, and its incremented value.
    always_comb begin
        c_sel = '0;
        for (int j = 0; j < VAR_LIMIT; j++) begin
            if (r_hit[j]) c_sel = IW'(j);
        end
    end
    assign c_selv  = r_idx[c_sel] + IW'(1);
    assign c_k_inc = r_k + KW'(1);

    // Mask of the current combination; indices past the mask width drop out.
    always_comb begin
        c_lex_mask = '0;
        for (int j = 0; j < VAR_LIMIT; j++) begin
            if ((KW'(j) < r_k) && (NW'(r_idx[j]) < NW'(MW))) begin
                c_lex_mask[MIW'(r_idx[j])] = 1'b1;
            end
        end
    end

    // Bits at or above n; any of them set means the candidate is out of range.
    always_comb begin
        for (int b = 0; b < GW; b++) begin
            c_himask[b] = (BW'(b) >= BW'(r_n));
        end
    end

    // Member counts of the plain Gray code and of the probe at bit position p.
    assign c_gy       = r_sh | GW'(1);
    assign c_pc_plain = PCW'($countones(r_sh ^ (r_sh >> 1)));
    assign c_pc_step  = PCW'($countones(c_gy ^ (c_gy >> 1)));
    assign c_m_h      = HW'(r_m);

    // First check of a search: the start value itself.
    assign c_start_fail  = (r_m == '0) || (|(r_c & c_himask));
    assign c_start_found = !c_start_fail && (HW'(c_pc_plain) <= c_m_h);

    // One bit position per cycle: raise bit p and keep or fill the bits below it.
    assign c_p_end      = (NW'(r_p) == r_n);
    assign c_hw_le      = (HW'(c_pc_step) <= c_m_h);
    assign c_hw1_le     = ((HW'(c_pc_step) + HW'(1)) <= c_m_h);
    assign c_x_base     = (r_c & ~r_low) | r_pbit;
    assign c_step_x     = (!r_pbit[0] && !c_hw1_le) ? (c_x_base | r_low) : c_x_base;
    assign c_step_acc   = !c_p_end && !r_sh[0] && c_hw_le;
    assign c_step_over  = |(c_step_x & c_himask);
    assign c_step_fail  = c_p_end || (c_step_acc && c_step_over);
    assign c_step_found = c_step_acc && !c_step_over;

    assign c_gray = r_x ^ (r_x >> 1);
    assign c_load = (i_op == bse_pkg::OP_GRAY_SIZE) ? (r_x + GW'(1))
                                                    : (GW'(r_gcnt) + GW'(1));

    // Enumeration state, cleared by reset and by a restart beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VAR_LIMIT; j++) r_idx[j] <= '0;
            r_k    <= '0;
            r_gcnt <= '0;
            r_done <= 1'b0;
        end else begin
            unique case (i_op)
                bse_pkg::OP_ACCEPT: begin
                    if (i_restart) begin
                        for (int j = 0; j < VAR_LIMIT; j++) r_idx[j] <= '0;
                        r_k    <= '0;
                        r_gcnt <= '0;
                        r_done <= 1'b0;
                    end
                end
                bse_pkg::OP_EXHAUST: r_done <= 1'b1;
                bse_pkg::OP_LEX_INIT: begin
                    r_k <= c_k_inc;
                    for (int j = 0; j < VAR_LIMIT; j++) begin
                        if (KW'(j) < c_k_inc) r_idx[j] <= IW'(j);
                    end
                end
                bse_pkg::OP_LEX_REFILL: begin
                    for (int j = 0; j < VAR_LIMIT; j++) begin
                        if ((IW + 1)'(j) == (IW + 1)'(r_sel)) begin
                            r_idx[j] <= r_selv;
                        end else if (((IW + 1)'(j) > (IW + 1)'(r_sel)) && (KW'(j) < r_k)) begin
                            r_idx[j] <= IW'((IW + 1)'(r_selv) + (IW + 1)'(j) - (IW + 1)'(r_sel));
                        end
                    end
                end
                bse_pkg::OP_GRAY_HIT: r_gcnt <= r_x[GCW-1:0];
                default: ;
            endcase
        end
    end

    // Working registers and the result of the step.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            bse_pkg::OP_ACCEPT: begin
                r_n <= eff_n;
                r_m <= eff_m;
            end
            bse_pkg::OP_LEX_CMP: r_hit <= c_hit;
            bse_pkg::OP_LEX_SEL: begin
                r_sel  <= c_sel;
                r_selv <= c_selv;
            end
            bse_pkg::OP_LEX_RES: begin
                r_res_mask  <= c_lex_mask;
                r_res_size  <= NW'(r_k);
                r_res_valid <= 1'b1;
                r_res_fin   <= (NW'(r_k) == r_m) && !(|r_hit);
            end
            bse_pkg::OP_EXHAUST: begin
                r_res_mask  <= '0;
                r_res_size  <= '0;
                r_res_valid <= 1'b0;
                r_res_fin   <= 1'b0;
            end
            bse_pkg::OP_GF_LOAD_CNT: begin
                r_c    <= c_load;
                r_sh   <= c_load;
                r_pbit <= GW'(1);
                r_low  <= '0;
                r_p    <= '0;
            end
            bse_pkg::OP_GF_START: begin
                if (c_start_found) r_x <= r_c;
            end
            bse_pkg::OP_GF_STEP: begin
                if (c_step_found) begin
                    r_x <= c_step_x;
                end else if (!c_step_fail) begin
                    r_sh   <= r_sh >> 1;
                    r_pbit <= r_pbit << 1;
                    r_low  <= (r_low << 1) | GW'(1);
                    r_p    <= r_p + KW'(1);
                end
            end
            bse_pkg::OP_GRAY_HIT: begin
                r_sh        <= r_x;
                r_res_mask  <= c_gray[MW-1:0];
                r_res_valid <= 1'b1;
                r_res_fin   <= 1'b0;
            end
            bse_pkg::OP_GRAY_SIZE: begin
                // Size of the emitted code, then set up the search for a successor.
                r_res_size <= c_pc_plain[NW-1:0];
                r_c        <= c_load;
                r_sh       <= c_load;
                r_pbit     <= GW'(1);
                r_low      <= '0;
                r_p        <= '0;
            end
            bse_pkg::OP_SET_FIN: r_res_fin <= 1'b1;
            default: ;
        endcase
    end

    // Output register valid: loaded on emit, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_op == bse_pkg::OP_EMIT) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_op == bse_pkg::OP_EMIT) begin
            r_o_mask    <= r_res_mask;
            r_o_size    <= r_res_size;
            r_o_valid_f <= r_res_valid;
            r_o_fin     <= r_res_fin;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.mode        = r_order_mode;
        o_status.done        = r_done;
        o_status.k_zero      = (r_k == '0);
        o_status.m_zero      = (r_m == '0);
        o_status.k_gt_m      = (NW'(r_k) > r_m);
        o_status.k_ge_m      = (NW'(r_k) >= r_m);
        o_status.any_hit     = |r_hit;
        o_status.start_found = c_start_found;
        o_status.start_fail  = c_start_fail;
        o_status.step_found  = c_step_found;
        o_status.step_fail   = c_step_fail;
        o_status.out_free    = !r_o_vld || !i_out_stall;
    end

    assign o_out_valid    = r_o_vld;
    assign o_mask         = r_o_mask;
    assign o_size         = r_o_size;
    assign o_subset_valid = r_o_valid_f;
    assign o_final        = r_o_fin;

endmodule

// ===== rtl/bounded_subset_enumerator.sv =====
`timescale 1ns / 1ps
// Top level of the bounded subset enumerator: controller and datapath.
// Each input beat asks for the next nonempty subset of the first num_vars variables (saturated
// to VAR_LIMIT) with at most size-bound members (clamped to that count); a beat with restart
// set starts over from the first subset. Every input beat yields exactly one output beat: a
// mask with its member count, a flag that a subset was produced, and a flag that it was the
// last. Once the enumeration is exhausted every further beat reports subset_valid low with all
// other fields zero, until a restart or reset. Order mode 0 walks sizes upward and, within a
// size, combinations in lexicographic order; order mode 1 walks Gray codes of a counter,
// skipping codes with too many members. One beat is handled at a time. In a lexicographic step
// the longest path is the one that advances an index and refills the ones to its right. A
// Gray step runs two bit-at-a-time successor searches over the counter (the code to emit and
// the check for a later one), and a final state marks the last code when no later code exists.
// The next input beat can be taken in the cycle after the result is loaded. The input stall is
// high while a beat is in work; a finished result waits in the output register, and the next
// input beat is taken while it waits. Configuration is to be written only while the block is
// idle; the block itself does not enforce this. Configuration takes effect at the next input
// beat.
module bounded_subset_enumerator #(
    parameter int VAR_LIMIT = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bse_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [bse_pkg::NW-1:0]     i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_restart,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bse_pkg::MW-1:0]     o_subset_mask,
    output logic [bse_pkg::NW-1:0]     o_subset_size,
    output logic                       o_subset_valid,
    output logic                       o_is_final
);

    bse_pkg::t_op     op;
    bse_pkg::t_status status;

    // Sequencer for one step.
    bse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_op     (op)
    );

    // Enumeration state, search logic and output register.
    bse_dpath #(
        .VAR_LIMIT (VAR_LIMIT)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (op),
        .i_restart      (i_restart),
        .i_out_stall    (i_stall),
        .o_status       (status),
        .o_out_valid    (o_valid),
        .o_mask         (o_subset_mask),
        .o_size         (o_subset_size),
        .o_subset_valid (o_subset_valid),
        .o_final        (o_is_final)
    );

endmodule

// ===== dv/tb_bounded_subset_enumerator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded subset enumerator: directed and random request streams.
module tb_bounded_subset_enumerator;

    localparam int VAR_LIMIT    = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1600;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [bse_pkg::MW-1:0] mask;
        logic [bse_pkg::NW-1:0] size;
        logic                   valid;
        logic                   fin;
    } t_subset;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [bse_pkg::CFG_IW-1:0] i_cfg_idx  = bse_pkg::CFG_NUM_VARS;
    logic [bse_pkg::NW-1:0]     i_cfg_data = '0;
    logic                       i_valid    = 1'b0;
    logic                       i_restart  = 1'b0;
    logic                       i_stall    = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [bse_pkg::MW-1:0]     o_subset_mask;
    logic [bse_pkg::NW-1:0]     o_subset_size;
    logic                       o_subset_valid;
    logic                       o_is_final;

    bounded_subset_enumerator #(.VAR_LIMIT(VAR_LIMIT)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_subset_mask  (o_subset_mask),
        .o_subset_size  (o_subset_size),
        .o_subset_valid (o_subset_valid),
        .o_is_final     (o_is_final)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copies of the configuration registers.
    logic [bse_pkg::NW-1:0] cfg_nvars = bse_pkg::NUM_VARS_RST;
    logic [bse_pkg::NW-1:0] cfg_bound = bse_pkg::SIZE_BOUND_RST;
    logic                   cfg_mode  = bse_pkg::ORDER_MODE_RST;

    // Predicted enumeration state.
    int            lex_idx [VAR_LIMIT];
    int            lex_k     = 0;
    logic [32:0]   gray_cnt  = '0;
    bit            enum_done = 1'b0;

    t_subset       pending_subsets[$];
    int            error_count = 0;
    int            items_sent  = 0;
    int            burst_left  = 0;
    bit            gapless     = 1'b0;
    logic          hold_toggle = 1'b0;

    // Loads the first combination of size k.
    function automatic void lex_load(input int k);
        int i;
        for (i = 0; i < k; i++) lex_idx[i] = i;
        lex_k = k;
    endfunction

    // Advances the lexicographic walk; returns 0 when it is over.
    function automatic bit lex_step(input int n, input int m);
        int k;
        int i;
        int j;
        k = lex_k;
        if (k == 0) begin
            if (m < 1) return 1'b0;
            lex_load(1);
            return 1'b1;
        end
        if (k > m) return 1'b0;
        for (i = k - 1; i >= 0; i--) begin
            if (lex_idx[i] < n - k + i) begin
                lex_idx[i]++;
                for (j = i + 1; j < k; j++) lex_idx[j] = lex_idx[j - 1] + 1;
                return 1'b1;
            end
        end
        if (k + 1 > m) return 1'b0;
        lex_load(k + 1);
        return 1'b1;
    endfunction

    // Smallest counter at or above c, below 2^n, whose Gray code has at most m ones.
    function automatic bit gray_search(input logic [63:0] c, input int n, input int m,
                                       output logic [63:0] hit);
        logic [63:0] bound;
        logic [63:0] y;
        logic [63:0] x;
        int          hw;
        int          p;
        bit          take;
        bit          stop;
        bit          ok;
        bound = 64'd1 << n;
        hit   = '0;
        x     = '0;
        ok    = 1'b0;
        stop  = 1'b0;
        if (m == 0 || c >= bound) return 1'b0;
        if ($countones(c ^ (c >> 1)) <= m) begin
            hit = c;
            return 1'b1;
        end
        // Find the lowest clear bit whose setting yields an acceptable code.
        for (p = 0; p < n && !stop; p++) begin
            if (!c[p]) begin
                y    = (c >> p) | 64'd1;
                hw   = $countones(y ^ (y >> 1));
                take = 1'b1;
                if (p == 0) begin
                    take = (hw <= m);
                    x    = y;
                end else if (hw + 1 <= m) begin
                    x = y << p;
                end else if (hw <= m) begin
                    x = (y << p) | ((64'd1 << p) - 64'd1);
                end else begin
                    take = 1'b0;
                end
                if (take) begin
                    stop = 1'b1;
                    if (x < bound) begin
                        ok  = 1'b1;
                        hit = x;
                    end
                end
            end
        end
        return ok;
    endfunction

    // Computes the result of one request and updates the predicted state.
    function automatic t_subset next_subset(input bit restart);
        t_subset     r;
        int          n;
        int          m;
        int          i;
        bit          grow;
        logic [63:0] x;
        logic [63:0] nx;
        logic [63:0] g;
        n = (cfg_nvars > VAR_LIMIT) ? VAR_LIMIT : int'(cfg_nvars);
        m = (int'(cfg_bound) > n) ? n : int'(cfg_bound);
        r = '0;
        if (restart) begin
            for (i = 0; i < VAR_LIMIT; i++) lex_idx[i] = 0;
            lex_k     = 0;
            gray_cnt  = '0;
            enum_done = 1'b0;
        end
        if (!enum_done) begin
            if (cfg_mode) begin
                if (gray_search({31'b0, gray_cnt} + 64'd1, n, m, x)) begin
                    gray_cnt = x[32:0];
                    g        = x ^ (x >> 1);
                    r.mask   = g[bse_pkg::MW-1:0];
                    r.size   = bse_pkg::NW'($countones(g));
                    r.valid  = 1'b1;
                    r.fin    = !gray_search(x + 64'd1, n, m, nx);
                end
            end else if (lex_step(n, m)) begin
                for (i = 0; i < lex_k; i++) r.mask[lex_idx[i]] = 1'b1;
                r.size  = bse_pkg::NW'(lex_k);
                r.valid = 1'b1;
                grow    = 1'b0;
                for (i = m - 1; i >= 0; i--) if (lex_idx[i] < n - m + i) grow = 1'b1;
                r.fin   = (lex_k == m) && !grow;
            end
            if (!r.valid) enum_done = 1'b1;
        end
        return r;
    endfunction

    // Sends one request beat, in bursts separated by random gaps.
    task automatic send_request(input bit restart);
        int      gap;
        t_subset exp_beat;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!gapless && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_restart <= restart;
        // The beat is taken at the edge after a negedge that sees no stall.
        do @(negedge i_clk); while (o_stall);
        exp_beat = next_subset(restart);
        pending_subsets.insert(pending_subsets.size(), exp_beat);
        items_sent++;
        @(posedge i_clk);
    endtask

    // Drops the request line and waits until every expected result has come.
    task automatic wait_until_drained();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (pending_subsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the selected registers while the block is idle.
    task automatic configure(input bit wr_n, input logic [bse_pkg::NW-1:0] n,
                             input bit wr_m, input logic [bse_pkg::NW-1:0] m,
                             input bit wr_mode, input bit mode);
        wait_until_drained();
        if (wr_n) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= bse_pkg::CFG_NUM_VARS;
            i_cfg_data <= n;
            cfg_nvars  = n;
            @(posedge i_clk);
        end
        if (wr_m) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= bse_pkg::CFG_SIZE_BOUND;
            i_cfg_data <= m;
            cfg_bound  = m;
            @(posedge i_clk);
        end
        if (wr_mode) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= bse_pkg::CFG_ORDER_MODE;
            i_cfg_data <= bse_pkg::NW'(mode);
            cfg_mode   = mode;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stall pattern, with a long hold-off on request.
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   seg_left  = 0;
    int   stall_pct = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                seg_left <= seg_left - 1;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compares each result beat with the oldest expectation.
    always @(negedge i_clk) begin : check_results
        t_subset got;
        t_subset want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_subset_mask, o_subset_size, o_subset_valid, o_is_final};
            if (pending_subsets.size() == 0) begin
                $error("result beat with nothing expected: mask %h", got.mask);
                error_count++;
            end else begin
                want = pending_subsets.pop_front();
                if (got.mask !== want.mask) begin
                    $error("subset_mask: expected %h, got %h", want.mask, got.mask);
                    error_count++;
                end
                if (got.size !== want.size) begin
                    $error("subset_size: expected %0d, got %0d", want.size, got.size);
                    error_count++;
                end
                if (got.valid !== want.valid) begin
                    $error("subset_valid: expected %b, got %b", want.valid, got.valid);
                    error_count++;
                end
                if (got.fin !== want.fin) begin
                    $error("is_final: expected %b, got %b", want.fin, got.fin);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    int idle_cycles = 0;
    always @(negedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register values after reset: single variables in order, then a restart.
    task automatic test_reset_defaults();
        repeat (3) send_request(1'b0);
        send_request(1'b1);
    endtask

    // No variables, or a size bound of zero, exhausts on the first request.
    task automatic test_empty_enumeration();
        configure(1'b1, 6'd0, 1'b0, '0, 1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        configure(1'b1, 6'd4, 1'b1, 6'd0, 1'b0, 1'b0);
        send_request(1'b1);
    endtask

    // A short lexicographic walk runs into its final subset and then exhaustion.
    task automatic test_exhaustion();
        configure(1'b1, 6'd2, 1'b1, 6'd63, 1'b1, 1'b0);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
    endtask

    // Gray order skips oversized codes; exhaustion sticks until a restart.
    task automatic test_gray_order();
        configure(1'b1, 6'd4, 1'b1, 6'd1, 1'b1, 1'b1);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        configure(1'b0, '0, 1'b1, 6'd2, 1'b0, 1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Mode and bound changes without a restart keep the enumeration state.
    task automatic test_config_change_midrun();
        configure(1'b1, 6'd5, 1'b1, 6'd3, 1'b1, 1'b0);
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        configure(1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
        repeat (2) send_request(1'b0);
        // Current size now exceeds the new bound, so the walk ends.
        configure(1'b0, '0, 1'b1, 6'd1, 1'b1, 1'b0);
        send_request(1'b0);
    endtask

    // Register values above the variable limit saturate.
    task automatic test_wide_extremes();
        configure(1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 1'b1);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // The receiver holds off while requests keep coming, so the block fills up.
    task automatic test_output_backpressure();
        configure(1'b1, 6'd6, 1'b1, 6'd3, 1'b1, 1'b0);
        hold_toggle <= ~hold_toggle;
        gapless = 1'b1;
        send_request(1'b1);
        repeat (11) send_request(1'b0);
        gapless = 1'b0;
    endtask

    // Random sessions: a new setting, mostly a restart, then a walk with stray restarts.
    task automatic test_random_walks();
        int                     target;
        int                     steps;
        int                     sel;
        bit                     wide;
        bit                     wr_n;
        bit                     wr_m;
        bit                     wr_mode;
        logic [bse_pkg::NW-1:0] n;
        logic [bse_pkg::NW-1:0] m;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sel  = $urandom_range(0, 9);
            wide = (sel == 9);
            if (wide) n = bse_pkg::NW'($urandom_range(32, 63));
            else if (sel < 6) n = bse_pkg::NW'($urandom_range(1, 7));
            else if (sel < 8) n = bse_pkg::NW'($urandom_range(8, 32));
            else n = bse_pkg::NW'($urandom_range(0, 63));
            if (wide) m = bse_pkg::NW'($urandom_range(1, 2));
            else if ($urandom_range(0, 3) == 0) m = bse_pkg::NW'($urandom_range(0, 63));
            else m = bse_pkg::NW'($urandom_range(1, 6));
            wr_n    = wide || ($urandom_range(0, 3) != 0);
            wr_m    = wide || ($urandom_range(0, 3) != 0);
            wr_mode = wide || !(wr_n || wr_m) || ($urandom_range(0, 1) == 1);
            configure(wr_n, n, wr_m, m, wr_mode, $urandom_range(0, 1));
            steps = wide ? $urandom_range(30, 40) : $urandom_range(4, 45);
            if ($urandom_range(0, 6) != 0) send_request(1'b1);
            repeat (steps) send_request($urandom_range(0, 24) == 0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_empty_enumeration();
        test_exhaustion();
        test_gray_order();
        test_config_change_midrun();
        test_wide_extremes();
        test_output_backpressure();
        test_random_walks();
        wait_until_drained();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bse_pkg.sv
rtl/bse_ctrl.sv
rtl/bse_dpath.sv
rtl/bounded_subset_enumerator.sv
dv/tb_bounded_subset_enumerator.sv
